[hw/rtl/b64bd_pkg.sv]
package b64bd_pkg;

   // Character codes that the line checker looks for.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Bit positions in the character class mask.
   localparam int CLS_LOWER  = 0;
   localparam int CLS_UPPER  = 1;
   localparam int CLS_DIGIT  = 2;
   localparam int CLS_SYMBOL = 3;

   // Register field widths and reset values.
   localparam int MIN_WIDTH_BITS  = 16;
   localparam int CLASS_WIDTH_BITS = 16;
   localparam int PAGE_LIMIT_BITS = 25;
   localparam int CSR_DATA_BITS   = 25;
   localparam int START_BITS      = 24;
   localparam int LENGTH_BITS     = 25;

   localparam logic [MIN_WIDTH_BITS-1:0]   MIN_LINE_WIDTH_RESET    = 16'd60;
   localparam logic [CLASS_WIDTH_BITS-1:0] CLASS_CHECK_WIDTH_RESET = 16'd160;
   localparam logic [PAGE_LIMIT_BITS-1:0]  PAGE_LIMIT_RESET        = 25'd16777216;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_MIN_LINE_WIDTH    = 2'd0,
      CSR_CLASS_CHECK_WIDTH = 2'd1,
      CSR_PAGE_LIMIT        = 2'd2
   } csr_index_type;

   // Decoded properties of one buffer byte.
   typedef struct packed {
      logic       newline;
      logic       space;
      logic       equals;
      logic       cap_a;
      logic [3:0] cls;
   } char_info_type;

   // Scanner status seen by the top level checks.
   typedef struct packed {
      logic       in_block;
      logic [1:0] line_count;
      logic       position_zero;
   } scan_status_type;

endpackage

[hw/rtl/b64bd_classify.sv]
module b64bd_classify
   import b64bd_pkg::*;
(
   input  logic [7:0]    data_byte,
   output char_info_type info
);

   // Sort the byte into whitespace, padding and the base64 character classes.
   always_comb begin
      info         = '0;
      info.newline = (data_byte == CHAR_NEWLINE);
      info.space   = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB) ||
                     (data_byte == CHAR_CR);
      info.equals  = (data_byte == CHAR_EQUALS);
      info.cap_a   = (data_byte == CHAR_UPPER_A);
      info.cls[CLS_LOWER]  = (data_byte >= CHAR_LOWER_A) && (data_byte <= CHAR_LOWER_Z);
      info.cls[CLS_UPPER]  = (data_byte >= CHAR_UPPER_A) && (data_byte <= CHAR_UPPER_Z);
      info.cls[CLS_DIGIT]  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
      info.cls[CLS_SYMBOL] = (data_byte == CHAR_PLUS) || (data_byte == CHAR_SLASH) ||
                             (data_byte == CHAR_MINUS) || (data_byte == CHAR_UNDER);
   end

endmodule

[hw/rtl/b64bd_scan.sv]
module b64bd_scan
   import b64bd_pkg::*;
#(
   parameter longint unsigned MAX_BUFFER_BYTES = 64'd16777216
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  char_info_type               info,
   input  logic                        end_of_buffer,
   input  logic [MIN_WIDTH_BITS-1:0]   min_line_width,
   input  logic [CLASS_WIDTH_BITS-1:0] class_check_width,
   input  logic [PAGE_LIMIT_BITS-1:0]  page_limit,
   output logic                        report,
   output logic [START_BITS-1:0]       block_start,
   output logic [LENGTH_BITS-1:0]      block_length,
   output scan_status_type             status
);

   localparam int PW = $clog2(MAX_BUFFER_BYTES + 64'd1);
   localparam int CW = (PW > PAGE_LIMIT_BITS) ? PW : PAGE_LIMIT_BITS;
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_BUFFER_BYTES);

   logic [PW-1:0] position_ff,     position_in;
   logic [PW-1:0] line_begin_ff,   line_begin_in;
   logic [PW-1:0] line_length_ff,  line_length_in;
   logic          line_bad_ff,     line_bad_in;
   logic          seen_equals_ff,  seen_equals_in;
   logic [3:0]    class_bits_ff,   class_bits_in;
   logic          only_a_ff,       only_a_in;
   logic          in_block_ff,     in_block_in;
   logic [PW-1:0] block_begin_ff,  block_begin_in;
   logic [PW-1:0] prev_length_ff,  prev_length_in;
   logic [1:0]    line_count_ff,   line_count_in;

   logic          pos_below_max;
   logic          absorb_en;
   logic          do_finish;
   logic [PW-1:0] len_a;
   logic          bad_a;
   logic          equals_a;
   logic [3:0]    cls_a;
   logic          only_a_a;
   logic          examined;
   logic          long_line;
   logic          line_valid;
   logic [PW-1:0] end_pos;

   assign pos_below_max = (position_ff < MAX_POS);
   assign absorb_en     = pos_below_max && !info.newline;
   assign do_finish     = pos_below_max ? (info.newline || end_of_buffer) : end_of_buffer;
   assign end_pos       = position_ff + PW'(absorb_en);

   // Fold the current byte into the line that is being collected.
   always_comb begin
      len_a    = line_length_ff;
      bad_a    = line_bad_ff;
      equals_a = seen_equals_ff;
      cls_a    = class_bits_ff;
      only_a_a = only_a_ff;
      if (absorb_en) begin
         if (line_length_ff < MAX_POS) begin
            len_a = line_length_ff + PW'(1);
         end
         if (!line_bad_ff && !info.space) begin
            if (info.equals) begin
               equals_a = 1'b1;
            end else if (seen_equals_ff || (info.cls == 4'd0)) begin
               bad_a = 1'b1;
            end else begin
               cls_a = class_bits_ff | info.cls;
               if (!info.cap_a) begin
                  only_a_a = 1'b0;
               end
            end
         end
      end
   end

   // Classify the finished line.
   assign examined   = (CW'(line_begin_ff) < CW'(page_limit));
   assign long_line  = (CW'(len_a) > CW'(class_check_width));
   assign line_valid = !bad_a &&
                       !(long_line && !only_a_a && !(cls_a[CLS_UPPER] && cls_a[CLS_LOWER]));

   // A block is reported when another length ends it after 2+ lines or an invalid line after 3+.
   always_comb begin
      report = 1'b0;
      if (do_finish && examined && in_block_ff) begin
         if (line_valid) begin
            report = (len_a != prev_length_ff) && (line_count_ff > 2'd1);
         end else begin
            report = (line_count_ff > 2'd2);
         end
      end
   end

   assign block_start  = START_BITS'(block_begin_ff);
   assign block_length = LENGTH_BITS'(end_pos - block_begin_ff);

   // Next state of the line and block trackers.
   always_comb begin
      position_in    = position_ff;
      line_begin_in  = line_begin_ff;
      line_length_in = len_a;
      line_bad_in    = bad_a;
      seen_equals_in = equals_a;
      class_bits_in  = cls_a;
      only_a_in      = only_a_a;
      in_block_in    = in_block_ff;
      block_begin_in = block_begin_ff;
      prev_length_in = prev_length_ff;
      line_count_in  = line_count_ff;

      if (pos_below_max) begin
         position_in = position_ff + PW'(1);
      end

      if (do_finish && examined) begin
         if (line_valid) begin
            if (!in_block_ff) begin
               if (CW'(len_a) >= CW'(min_line_width)) begin
                  in_block_in    = 1'b1;
                  block_begin_in = line_begin_ff;
                  line_count_in  = 2'd1;
                  prev_length_in = len_a;
               end
            end else if (len_a != prev_length_ff) begin
               in_block_in = 1'b0;
            end else if (line_count_ff != 2'd3) begin
               line_count_in = line_count_ff + 2'd1;
            end
         end else begin
            in_block_in = 1'b0;
         end
      end

      // A newline opens a fresh line just past itself.
      if (pos_below_max && info.newline) begin
         line_begin_in  = position_ff + PW'(1);
         line_length_in = '0;
         line_bad_in    = 1'b0;
         seen_equals_in = 1'b0;
         class_bits_in  = '0;
         only_a_in      = 1'b1;
      end

      // The last byte of a buffer clears everything.
      if (end_of_buffer) begin
         position_in    = '0;
         line_begin_in  = '0;
         line_length_in = '0;
         line_bad_in    = 1'b0;
         seen_equals_in = 1'b0;
         class_bits_in  = '0;
         only_a_in      = 1'b1;
         in_block_in    = 1'b0;
         block_begin_in = '0;
         prev_length_in = '0;
         line_count_in  = '0;
      end
   end

   // State registers, updated once per word taken from the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         line_begin_ff  <= '0;
         line_length_ff <= '0;
         line_bad_ff    <= 1'b0;
         seen_equals_ff <= 1'b0;
         class_bits_ff  <= '0;
         only_a_ff      <= 1'b1;
         in_block_ff    <= 1'b0;
         block_begin_ff <= '0;
         prev_length_ff <= '0;
         line_count_ff  <= '0;
      end else if (advance) begin
         position_ff    <= position_in;
         line_begin_ff  <= line_begin_in;
         line_length_ff <= line_length_in;
         line_bad_ff    <= line_bad_in;
         seen_equals_ff <= seen_equals_in;
         class_bits_ff  <= class_bits_in;
         only_a_ff      <= only_a_in;
         in_block_ff    <= in_block_in;
         block_begin_ff <= block_begin_in;
         prev_length_ff <= prev_length_in;
         line_count_ff  <= line_count_in;
      end
   end

   assign status.in_block      = in_block_ff;
   assign status.line_count    = line_count_ff;
   assign status.position_zero = (position_ff == '0);

endmodule

[hw/rtl/base64_block_detector.sv]
// A word accepted into the input register loads its block report into the result
// register when the input register moves on.
// Throughput: one byte per cycle while the result register is not stalled; the
// state update for a byte is one pass between the input and result registers.
// Reset (synchronous, active high) clears all line and block state, empties both
// registers and restores the configuration to 60, 160 and 2^24.
module base64_block_detector
   import b64bd_pkg::*;
#(
   parameter longint unsigned MAX_BUFFER_BYTES = 64'd16777216
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_end_of_buffer,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [START_BITS-1:0]    rsp_block_start,
   output logic [LENGTH_BITS-1:0]   rsp_block_length,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic [MIN_WIDTH_BITS-1:0]   min_line_width_ff;
   logic [CLASS_WIDTH_BITS-1:0] class_check_width_ff;
   logic [PAGE_LIMIT_BITS-1:0]  page_limit_ff;

   logic                   in_valid_ff, in_valid_in;
   char_info_type          in_info_ff;
   logic                   in_eob_ff;
   char_info_type          byte_info;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [START_BITS-1:0]  rsp_start_ff;
   logic [LENGTH_BITS-1:0] rsp_length_ff;

   logic                   out_ready;
   logic                   advance;
   logic                   req_accept;
   logic                   report;
   logic [START_BITS-1:0]  block_start;
   logic [LENGTH_BITS-1:0] block_length;
   scan_status_type        status;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_line_width_ff    <= MIN_LINE_WIDTH_RESET;
         class_check_width_ff <= CLASS_CHECK_WIDTH_RESET;
         page_limit_ff        <= PAGE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_LINE_WIDTH: begin
               min_line_width_ff <= csr_data[MIN_WIDTH_BITS-1:0];
            end
            CSR_CLASS_CHECK_WIDTH: begin
               class_check_width_ff <= csr_data[CLASS_WIDTH_BITS-1:0];
            end
            CSR_PAGE_LIMIT: begin
               page_limit_ff <= csr_data[PAGE_LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result register can load.
   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_ready;
   assign req_stall   = in_valid_ff && !out_ready;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !out_ready);

   b64bd_classify u_classify (
      .data_byte (req_data_byte),
      .info      (byte_info)
   );

   // Input register holds the decoded byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_info_ff <= byte_info;
         in_eob_ff  <= req_end_of_buffer;
      end
   end

   b64bd_scan #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_scan (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .info              (in_info_ff),
      .end_of_buffer     (in_eob_ff),
      .min_line_width    (min_line_width_ff),
      .class_check_width (class_check_width_ff),
      .page_limit        (page_limit_ff),
      .report            (report),
      .block_start       (block_start),
      .block_length      (block_length),
      .status            (status)
   );

   // Result register.
   assign rsp_valid_in = out_ready ? (advance && report) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && report) begin
         rsp_start_ff  <= block_start;
         rsp_length_ff <= block_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_start  = rsp_start_ff;
   assign rsp_block_length = rsp_length_ff;

`ifndef SYNTHESIS
   // An open block always counts at least its first line.
   assert property (@(posedge clock) disable iff (reset)
      status.in_block |-> (status.line_count != 2'd0))
      else $error("open block with zero line count");

   // The final byte of a buffer leaves the scanner cleared.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_eob_ff) |=> (status.position_zero && !status.in_block))
      else $error("state not cleared after end of buffer");

   // A reported block spans at least one byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length_ff != '0))
      else $error("reported block has zero length");

   // A result can only be loaded from a block that was open.
   assert property (@(posedge clock) disable iff (reset)
      (advance && report) |-> status.in_block)
      else $error("report without an open block");
`endif

endmodule
